/* hw/rtl/ihq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihq_pkg
// Shared codes and field widths for the indexed max-heap queue.
// ----------------------------------------------------------------------------
package ihq_pkg;

    localparam int FUNC_W     = 3;
    localparam int HANDLE_W   = 8;
    localparam int PRIO_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 9;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 3'd0,
        FUNC_POP    = 3'd1,
        FUNC_PEEK   = 3'd2,
        FUNC_CHANGE = 3'd3,
        FUNC_REMOVE = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HMOD,
        S_TOP_RD,
        S_TOP_GET,
        S_LAST_GET,
        S_POS_RD,
        S_POS_GET,
        S_OLD_GET,
        S_UP,
        S_UP_GET,
        S_DN_L,
        S_DN_LGET,
        S_DN_RGET,
        S_DN_CMP,
        S_FIN,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/ihq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihq_req_if / ihq_rsp_if
// Request and response channels of the heap queue, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ihq_req_if;
    import ihq_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   priority_req;

    modport source (output valid, func, handle, priority_req, input ready);
    modport sink   (input valid, func, handle, priority_req, output ready);
endinterface

interface ihq_rsp_if;
    import ihq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [PRIO_W-1:0]   out_priority;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, out_handle, out_priority, entry_count,
                    input ready);
    modport sink   (input valid, status, out_handle, out_priority, entry_count,
                    output ready);
endinterface

/* hw/rtl/ihq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ihq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule

/* hw/rtl/indexed_max_heap_queue_top.sv */
`timescale 1ns / 1ps
// Empty, full and unused-code requests go straight to the result word; insert climbs
//   level by level, pop descends level by level; remove is a pop then a re-sift.
// Throughput: one word at a time; ready returns the cycle after the result is taken.
// Reset: synchronous, active low; empties the queue. RAM contents are kept.
// ----------------------------------------------------------------------------
// indexed_max_heap_queue_top
// Indexed binary max-heap: insert, pop, peek, change priority, remove handle.
// ----------------------------------------------------------------------------
module indexed_max_heap_queue_top #(
    parameter int CAPACITY      = 256,
    parameter int HANDLE_COUNT  = 256,
    parameter int PRIORITY_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ihq_req_if.sink   i_req,
    ihq_rsp_if.source o_rsp
);
    import ihq_pkg::*;

    localparam int SW = $clog2(CAPACITY + 1);   // slot index / count width
    localparam int HW = $clog2(HANDLE_COUNT);   // handle width
    localparam int PB = PRIORITY_BITS;
    localparam int DW = HW + PB;                // slot word width

    t_state r_state, n_state;

    logic [FUNC_W-1:0]   r_func;
    logic [HANDLE_W-1:0] r_h;
    logic signed [PB-1:0] r_key;
    logic [SW-1:0]       r_count;
    logic [SW-1:0]       r_i, r_c, r_pos;
    logic [HW-1:0]       r_cur_h, r_best_h, r_top_h;
    logic signed [PB-1:0] r_cur_p, r_best_p, r_top_p;
    logic                r_phase2;
    t_status             r_status;
    logic [HANDLE_W-1:0] r_oh;
    logic signed [PB-1:0] r_op;

    // RAM ports
    logic          slot_we, pos_we;
    logic [SW-1:0] slot_waddr, slot_raddr;
    logic [DW-1:0] slot_wdata, slot_rdata;
    logic [HW-1:0] pos_waddr, pos_raddr;
    logic [SW-1:0] pos_wdata, pos_rdata;

    logic [HW-1:0]        rd_h;
    logic signed [PB-1:0] rd_p;
    logic [SW:0]          w_l, w_r, w_cnt;
    logic                 w_hbig, w_pos_ok;
    logic signed [PB-1:0] w_newp;

    assign rd_h  = slot_rdata[DW-1:PB];
    assign rd_p  = $signed(slot_rdata[PB-1:0]);
    assign w_l   = {r_i, 1'b0};
    assign w_r   = {r_i, 1'b1};
    assign w_cnt = {1'b0, r_count};
    assign w_hbig = {9'd0, r_h} >= 17'(HANDLE_COUNT);
    assign w_pos_ok = (pos_rdata != '0) && (pos_rdata <= r_count);
    assign w_newp = r_phase2 ? r_top_p : r_key;

    ihq_ram #(.DEPTH(CAPACITY + 1), .WIDTH(DW)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    ihq_ram #(.DEPTH(HANDLE_COUNT), .WIDTH(SW)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    // handshake and result
    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = (r_state == S_DONE);
    assign o_rsp.status       = r_status;
    assign o_rsp.out_handle   = r_oh;
    assign o_rsp.out_priority = PRIO_W'(r_op);
    assign o_rsp.entry_count  = COUNT_W'(r_count);

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) n_state = S_HMOD;
            end
            S_HMOD: begin
                if (!w_hbig) begin
                    unique case (r_func) inside
                        FUNC_INSERT:
                            n_state = (r_count >= SW'(CAPACITY)) ? S_DONE : S_UP;
                        FUNC_POP, FUNC_PEEK, FUNC_REMOVE:
                            n_state = (r_count == '0) ? S_DONE : S_TOP_RD;
                        FUNC_CHANGE: n_state = S_POS_RD;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_TOP_RD:   n_state = S_TOP_GET;
            S_TOP_GET:  n_state = (r_func == FUNC_PEEK) ? S_DONE : S_LAST_GET;
            S_LAST_GET: n_state = S_DN_L;
            S_POS_RD:   n_state = S_POS_GET;
            S_POS_GET:  n_state = w_pos_ok ? S_OLD_GET : S_DONE;
            S_OLD_GET:  n_state = (w_newp > rd_p) ? S_UP : S_DN_L;
            S_UP:       n_state = (r_i > SW'(1)) ? S_UP_GET : S_FIN;
            S_UP_GET:   n_state = (rd_p < r_cur_p) ? S_UP : S_FIN;
            S_DN_L:     n_state = (w_l > w_cnt) ? S_FIN : S_DN_LGET;
            S_DN_LGET:  n_state = (w_r <= w_cnt) ? S_DN_RGET : S_DN_CMP;
            S_DN_RGET:  n_state = S_DN_CMP;
            S_DN_CMP:   n_state = (r_best_p > r_cur_p) ? S_DN_L : S_FIN;
            S_FIN: begin
                if (r_func == FUNC_REMOVE && !r_phase2 && r_top_h != HW'(r_h))
                    n_state = S_POS_RD;
                else
                    n_state = S_DONE;
            end
            S_DONE: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer: RAM controls
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_i;
        slot_wdata = {r_cur_h, r_cur_p};
        slot_raddr = SW'(1);
        pos_we     = 1'b0;
        pos_waddr  = r_cur_h;
        pos_wdata  = r_i;
        pos_raddr  = HW'(r_h);
        unique case (r_state)
            S_TOP_GET:  slot_raddr = r_count;
            S_POS_GET:  slot_raddr = pos_rdata;
            S_UP:       slot_raddr = r_i >> 1;
            S_UP_GET: begin
                // parent moves down into the hole
                if (rd_p < r_cur_p) begin
                    slot_we    = 1'b1;
                    slot_wdata = slot_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = rd_h;
                end
            end
            S_DN_L:     slot_raddr = SW'(w_l);
            S_DN_LGET:  slot_raddr = SW'(w_r);
            S_DN_CMP: begin
                // larger child moves up into the hole
                if (r_best_p > r_cur_p) begin
                    slot_we    = 1'b1;
                    slot_wdata = {r_best_h, r_best_p};
                    pos_we     = 1'b1;
                    pos_waddr  = r_best_h;
                end
            end
            S_FIN: begin
                // a change that never left its slot leaves the position table as it is
                slot_we = 1'b1;
                pos_we  = !(r_func == FUNC_CHANGE && r_i == r_pos);
            end
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_HMOD && !w_hbig && r_func == FUNC_INSERT
                    && r_count < SW'(CAPACITY))
                r_count <= r_count + SW'(1);
            else if (r_state == S_LAST_GET)
                r_count <= r_count - SW'(1);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_func   <= i_req.func;
                r_h      <= i_req.handle;
                r_key    <= PB'($signed(i_req.priority_req));
                r_phase2 <= 1'b0;
                r_status <= ST_OK;
                r_oh     <= '0;
                r_op     <= '0;
            end
            S_HMOD: begin
                if (w_hbig) begin
                    r_h <= r_h - HANDLE_W'(HANDLE_COUNT);
                end else begin
                    case (r_func) inside
                        FUNC_INSERT: begin
                            if (r_count >= SW'(CAPACITY)) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_i     <= r_count + SW'(1);
                                r_cur_h <= HW'(r_h);
                                r_cur_p <= r_key;
                            end
                        end
                        FUNC_POP, FUNC_PEEK, FUNC_REMOVE: begin
                            if (r_count == '0) r_status <= ST_EMPTY;
                        end
                        default: ;
                    endcase
                end
            end
            S_TOP_GET: begin
                r_top_h <= rd_h;
                r_top_p <= rd_p;
                if (r_func == FUNC_REMOVE) begin
                    r_oh <= r_h;
                end else begin
                    r_oh <= HANDLE_W'(rd_h);
                    r_op <= rd_p;
                end
            end
            S_LAST_GET: begin
                r_cur_h <= rd_h;
                r_cur_p <= rd_p;
                r_i     <= SW'(1);
            end
            S_POS_GET: r_pos <= pos_rdata;
            S_OLD_GET: begin
                r_i     <= r_pos;
                r_cur_p <= w_newp;
                r_cur_h <= r_phase2 ? r_top_h : rd_h;
            end
            S_UP_GET: begin
                if (rd_p < r_cur_p) r_i <= r_i >> 1;
            end
            S_DN_LGET: begin
                r_best_h <= rd_h;
                r_best_p <= rd_p;
                r_c      <= SW'(w_l);
            end
            S_DN_RGET: begin
                if (rd_p > r_best_p) begin
                    r_best_h <= rd_h;
                    r_best_p <= rd_p;
                    r_c      <= SW'(w_r);
                end
            end
            S_DN_CMP: begin
                if (r_best_p > r_cur_p) r_i <= r_c;
            end
            S_FIN: begin
                if (r_func == FUNC_REMOVE) r_phase2 <= 1'b1;
            end
            default: ;
        endcase
    end
endmodule

/* hw/rtl/ihq_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihq_chk
// Port-level checks on the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module ihq_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [ihq_pkg::STATUS_W-1:0] i_status,
    input logic [ihq_pkg::HANDLE_W-1:0] i_out_handle,
    input logic [ihq_pkg::PRIO_W-1:0]   i_out_priority,
    input logic [ihq_pkg::COUNT_W-1:0]  i_entry_count
);
    import ihq_pkg::*;

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid &&
        $stable({i_status, i_out_handle, i_out_priority, i_entry_count}))
        else $error("result word changed while stalled");

    // one word in flight: no new request while a result waits
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("request taken while result pending");

    // busy right after an accepted request
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("ready straight after accept");

    // an empty report comes only with no entries held
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ST_EMPTY |-> i_entry_count == '0)
        else $error("empty status with entries held");
endmodule

bind indexed_max_heap_queue_top ihq_chk u_ihq_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_out_handle   (o_rsp.out_handle),
    .i_out_priority (o_rsp.out_priority),
    .i_entry_count  (o_rsp.entry_count)
);

/* dv/indexed_max_heap_queue_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_max_heap_queue_top_tb
// Drives insert, pop, peek, change and remove words into the heap queue and
// compares every response against an in-bench indexed max-heap predictor.
// ----------------------------------------------------------------------------
module indexed_max_heap_queue_top_tb;
    import ihq_pkg::*;

    localparam int CAP        = 256;
    localparam int NHANDLE    = 256;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] hnd;
        logic [PRIO_W-1:0]   prio;
        logic [COUNT_W-1:0]  count;
    } t_resp;

    // Heap predictor and queue of responses still owed by the block
    class heap_scoreboard;
        logic [HANDLE_W-1:0]      hslot [CAP+1];
        logic signed [PRIO_W-1:0] pslot [CAP+1];
        int unsigned              where [NHANDLE];
        bit                       known [NHANDLE];
        int unsigned              held;
        t_resp                    owed [$];
        int                       errors;

        function void clear();
            held = 0;
            errors = 0;
            owed.delete();
            foreach (known[i]) known[i] = 0;
            foreach (where[i]) where[i] = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic [HANDLE_W-1:0] th;
            logic signed [PRIO_W-1:0] tp;
            th = hslot[a]; tp = pslot[a];
            hslot[a] = hslot[b]; pslot[a] = pslot[b];
            hslot[b] = th; pslot[b] = tp;
            where[hslot[a]] = a;
            where[hslot[b]] = b;
        endfunction

        function void climb(int unsigned i);
            while (i > 1 && pslot[i/2] < pslot[i]) begin
                swap_slots(i, i / 2);
                i = i / 2;
            end
        endfunction

        function void descend(int unsigned i);
            int unsigned l, c;
            forever begin
                l = 2 * i;
                if (l > held) break;
                c = l;
                if (l + 1 <= held && pslot[l+1] > pslot[l]) c = l + 1;
                if (!(pslot[c] > pslot[i])) break;
                swap_slots(i, c);
                i = c;
            end
        endfunction

        function void take_top(output logic [HANDLE_W-1:0] h,
                               output logic signed [PRIO_W-1:0] p);
            h = hslot[1]; p = pslot[1];
            hslot[1] = hslot[held]; pslot[1] = pslot[held];
            held--;
            where[hslot[1]] = 1;
            descend(1);
        endfunction

        // Note an accepted request and predict its response
        function void note_request(t_func f, logic [HANDLE_W-1:0] h,
                                   logic signed [PRIO_W-1:0] p);
            t_resp r;
            logic [HANDLE_W-1:0] th;
            logic signed [PRIO_W-1:0] tp, old;
            int unsigned pos;
            r = '0;
            r.status = ST_OK;
            case (f) inside
                FUNC_INSERT: begin
                    if (held >= CAP) r.status = ST_FULL;
                    else begin
                        held++;
                        hslot[held] = h; pslot[held] = p;
                        where[h] = held; known[h] = 1;
                        climb(held);
                    end
                end
                FUNC_POP, FUNC_PEEK: begin
                    if (held == 0) r.status = ST_EMPTY;
                    else begin
                        if (f == FUNC_POP) take_top(th, tp);
                        else begin th = hslot[1]; tp = pslot[1]; end
                        r.hnd = th; r.prio = tp;
                    end
                end
                FUNC_CHANGE: begin
                    pos = where[h];
                    if (pos >= 1 && pos <= held) begin
                        old = pslot[pos];
                        pslot[pos] = p;
                        if (p > old) climb(pos); else descend(pos);
                    end
                end
                FUNC_REMOVE: begin
                    if (held == 0) r.status = ST_EMPTY;
                    else begin
                        take_top(th, tp);
                        r.hnd = h;
                        pos = where[h];
                        if (th != h && pos >= 1 && pos <= held) begin
                            old = pslot[pos];
                            hslot[pos] = th; pslot[pos] = tp;
                            where[th] = pos;
                            if (tp > old) climb(pos); else descend(pos);
                        end
                    end
                end
                default: ;
            endcase
            r.count = COUNT_W'(held);
            owed.push_back(r);
        endfunction

        // Compare one response word with the oldest prediction
        function void check_response(t_resp got);
            t_resp e;
            if (owed.size() == 0) begin
                $error("response with nothing outstanding");
                errors++;
                return;
            end
            e = owed.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.hnd !== e.hnd) begin
                $error("out_handle exp %0d got %0d", e.hnd, got.hnd); errors++;
            end
            if (got.prio !== e.prio) begin
                $error("out_priority exp %0d got %0d", $signed(e.prio),
                       $signed(got.prio));
                errors++;
            end
            if (got.count !== e.count) begin
                $error("entry_count exp %0d got %0d", e.count, got.count); errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    ihq_req_if req_if ();
    ihq_rsp_if rsp_if ();

    indexed_max_heap_queue_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    heap_scoreboard sb;
    int  idle_cycles;
    bit  sending_done;
    bit  hold_rsp;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request word and wait until it is taken; the block is never
    // ready the cycle after an accept, so valid is dropped between words
    task automatic send_word(t_func f, logic [HANDLE_W-1:0] h, logic [PRIO_W-1:0] p);
        int g;
        g = gap_len();
        repeat (g + 1) @(posedge i_clk);
        req_if.valid        <= 1'b1;
        req_if.func         <= f;
        req_if.handle       <= h;
        req_if.priority_req <= p;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(f, h, p);
        req_if.valid <= 1'b0;
    endtask

    // Pick a handle, preferring one that has been inserted at some point
    function automatic logic [HANDLE_W-1:0] known_handle();
        logic [HANDLE_W-1:0] h;
        if (sb.held > 0 && $urandom_range(0, 3) != 0)
            return sb.hslot[$urandom_range(1, sb.held)];
        repeat (20) begin
            h = HANDLE_W'($urandom);
            if (sb.known[h]) return h;
        end
        return sb.hslot[1];
    endfunction

    function automatic logic [PRIO_W-1:0] rand_prio();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Response side: random stalls, and one long hold-off during fill
    initial begin
        int g;
        rsp_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_response({rsp_if.status, rsp_if.out_handle,
                                   rsp_if.out_priority, rsp_if.entry_count});
            if (hold_rsp) rsp_if.ready <= 1'b0;
            else if (g > 0) begin
                g--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) g = gap_len();
            end
        end
    end

    // Watchdog on cycles with no accepted word
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else if (sending_done && sb.owed.size() == 0)
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("indexed_max_heap_queue_top verification failed");
                $finish;
            end
        end
    end

    // Main stimulus
    initial begin
        logic [HANDLE_W-1:0] h;
        int r;
        sb = new();
        sb.clear();
        sending_done = 0;
        hold_rsp = 0;
        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.func <= FUNC_INSERT;
        req_if.handle <= '0;
        req_if.priority_req <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty cases, extremes, each operation
        send_word(FUNC_POP, 8'd0, '0);
        send_word(FUNC_PEEK, 8'd0, '0);
        send_word(FUNC_REMOVE, 8'd5, '0);
        send_word(FUNC_INSERT, 8'd0, 32'h8000_0000);
        send_word(FUNC_INSERT, 8'd255, 32'h7FFF_FFFF);
        send_word(FUNC_INSERT, 8'd170, 32'd0);
        send_word(FUNC_INSERT, 8'd85, 32'hFFFF_FFFF);
        send_word(FUNC_PEEK, 8'd0, '0);
        send_word(FUNC_CHANGE, 8'd0, 32'h7FFF_FFFF);
        send_word(FUNC_CHANGE, 8'd255, 32'h8000_0000);
        send_word(FUNC_INSERT, 8'd85, 32'd100);        // duplicate handle
        send_word(FUNC_REMOVE, 8'd170, '0);
        send_word(t_func'(3'd5), 8'd1, 32'd1);          // unused codes
        send_word(t_func'(3'd7), 8'd2, 32'd2);
        send_word(FUNC_POP, 8'd0, '0);
        send_word(FUNC_REMOVE, 8'd85, '0);              // may be stale
        send_word(FUNC_POP, 8'd0, '0);

        // Fill to capacity with the response side held off, then overflow
        hold_rsp = 1;
        fork
            begin
                while (sb.held < CAP) send_word(FUNC_INSERT, sb.held[7:0], $urandom);
                send_word(FUNC_INSERT, 8'd9, 32'd1);
            end
            begin
                repeat (600) @(posedge i_clk);
                hold_rsp = 0;
            end
        join
        hold_rsp = 0;
        repeat (40) send_word(FUNC_CHANGE, known_handle(), rand_prio());
        repeat (60) send_word(FUNC_REMOVE, known_handle(), '0);
        while (sb.held > 0) send_word(FUNC_POP, 8'd0, '0);

        // Random phase, biased towards well-formed traffic on known handles
        for (int i = 0; i < 1280; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) send_word(FUNC_INSERT, HANDLE_W'($urandom), rand_prio());
            else if (r < 55) send_word(FUNC_POP, HANDLE_W'($urandom), $urandom);
            else if (r < 63) send_word(FUNC_PEEK, HANDLE_W'($urandom), $urandom);
            else if (r < 80) begin
                h = known_handle();
                if (sb.known[h]) send_word(FUNC_CHANGE, h, rand_prio());
                else send_word(FUNC_PEEK, h, '0);
            end else if (r < 97) begin
                h = known_handle();
                if (sb.known[h] || sb.held == 0) send_word(FUNC_REMOVE, h, '0);
                else send_word(FUNC_POP, h, '0);
            end else send_word(t_func'($urandom_range(5, 7)), HANDLE_W'($urandom),
                               $urandom);
        end

        // Drain to empty
        while (sb.held > 0) send_word(FUNC_POP, 8'd0, '0);
        sending_done = 1;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("indexed_max_heap_queue_top verification clean");
        else
            $display("indexed_max_heap_queue_top verification failed");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/ihq_pkg.sv
hw/rtl/ihq_if.sv
hw/rtl/ihq_ram.sv
hw/rtl/indexed_max_heap_queue_top.sv
hw/rtl/ihq_chk.sv
dv/indexed_max_heap_queue_top_tb.sv
